FILE: hw/rtl/brl_pkg.sv
package brl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 32;

    // Opcode of an input request.
    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

endpackage

FILE: hw/rtl/brl_in_reg.sv
module brl_in_reg
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  op_t                          op,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_BITS-1:0] draw_color,
    input  logic                         take,
    output logic                         held_valid,
    output op_t                          held_op,
    output logic signed [COORD_BITS-1:0] held_x1,
    output logic signed [COORD_BITS-1:0] held_y1,
    output logic signed [COORD_BITS-1:0] held_x2,
    output logic signed [COORD_BITS-1:0] held_y2,
    output logic        [COLOR_BITS-1:0] held_color
);

    logic                         valid_reg;
    logic                         valid_next;
    logic                         load;
    op_t                          op_reg;
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;
    logic        [COLOR_BITS-1:0] color_reg;

    // The register is free when it is empty or its request moves on this cycle.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (!valid_reg || take)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= op;
            x1_reg    <= x_start;
            y1_reg    <= y_start;
            x2_reg    <= x_end;
            y2_reg    <= y_end;
            color_reg <= draw_color;
        end
    end

    assign held_valid = valid_reg;
    assign held_op    = op_reg;
    assign held_x1    = x1_reg;
    assign held_y1    = y1_reg;
    assign held_x2    = x2_reg;
    assign held_y2    = y2_reg;
    assign held_color = color_reg;

endmodule

FILE: hw/rtl/brl_engine.sv
module brl_engine
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  op_t                          op,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic        [COLOR_BITS-1:0] color,
    output logic signed [COORD_BITS-1:0] res_x,
    output logic signed [COORD_BITS-1:0] res_y,
    output logic        [COLOR_BITS-1:0] res_color,
    output logic                         res_last,
    output logic                         res_valid
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int SW = COORD_BITS + 2;
    localparam int NW = COORD_BITS + 1;

    // Line state.
    logic signed [CB-1:0] cur_x_reg, cur_x_next;
    logic signed [CB-1:0] cur_y_reg, cur_y_next;
    logic signed [DW-1:0] dec_reg, dec_next;
    logic signed [SW-1:0] inc_s_reg, inc_s_next;
    logic signed [DW-1:0] inc_d_reg, inc_d_next;
    logic signed [1:0]    sxs_reg, sxs_next;
    logic signed [1:0]    sxd_reg, sxd_next;
    logic signed [1:0]    sys_reg, sys_next;
    logic signed [1:0]    syd_reg, syd_next;
    logic [NW-1:0]        left_reg, left_next;
    logic                 active_reg, active_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    // Set-up of a new line.
    logic signed [CB:0]   diff_x, diff_y, neg_x, neg_y;
    logic [CB-1:0]        dx, dy;
    logic                 same_x, same_y, x_gt, y_gt;
    logic [DW-1:0]        dx_e, dy_e, dx2, dy2;
    logic signed [CB-1:0] s_x, s_y;
    logic signed [DW-1:0] s_dec, s_inc_d;
    logic signed [SW-1:0] s_inc_s;
    logic signed [1:0]    s_sxs, s_sxd, s_sys, s_syd;
    logic [NW-1:0]        s_count;

    // Working values: the new line on a start, the stored one on an advance.
    logic                  is_start, emit_ok, last;
    logic signed [CB-1:0]  w_x, w_y;
    logic signed [DW-1:0]  w_dec, w_inc_d;
    logic signed [SW-1:0]  w_inc_s;
    logic signed [1:0]     w_sxs, w_sxd, w_sys, w_syd, step_x, step_y;
    logic [NW-1:0]         w_left, left_dec;
    logic [COLOR_BITS-1:0] w_color;
    logic                  straight;
    logic signed [CB-1:0]  adv_x, adv_y;
    logic signed [DW-1:0]  adv_dec;

    always_comb
    begin
        diff_x = {x1[CB-1], x1} - {x2[CB-1], x2};
        diff_y = {y1[CB-1], y1} - {y2[CB-1], y2};
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        dx     = diff_x[CB] ? neg_x[CB-1:0] : diff_x[CB-1:0];
        dy     = diff_y[CB] ? neg_y[CB-1:0] : diff_y[CB-1:0];
        same_x = (diff_x == '0);
        same_y = (diff_y == '0);
        x_gt   = !diff_x[CB] && !same_x;
        y_gt   = !diff_y[CB] && !same_y;
        dx_e   = {3'b000, dx};
        dy_e   = {3'b000, dy};
        dx2    = {2'b00, dx, 1'b0};
        dy2    = {2'b00, dy, 1'b0};

        s_x     = x1;
        s_y     = y1;
        s_dec   = '1;
        s_inc_s = '0;
        s_inc_d = '0;
        s_sxs   = 2'sd0;
        s_sxd   = 2'sd0;
        s_sys   = 2'sd0;
        s_syd   = 2'sd0;
        s_count = {1'b0, dx} + NW'(1);

        if (same_x || same_y)
        begin
            // Axis-aligned: a negative decision that never moves keeps every
            // step straight, running from the lower coordinate upwards.
            if (same_x)
            begin
                s_y     = diff_y[CB] ? y1 : y2;
                s_sys   = 2'sd1;
                s_count = {1'b0, dy} + NW'(1);
            end
            else
            begin
                s_x   = diff_x[CB] ? x1 : x2;
                s_sxs = 2'sd1;
            end
        end
        else
        begin
            if (dx >= dy)
            begin
                s_dec   = dy2 - dx_e;
                s_inc_s = {1'b0, dy, 1'b0};
                s_inc_d = dy2 - dx2;
                s_sxs   = 2'sd1;
                s_sxd   = 2'sd1;
                s_syd   = 2'sd1;
            end
            else
            begin
                s_count = {1'b0, dy} + NW'(1);
                s_dec   = dx2 - dy_e;
                s_inc_s = {1'b0, dx, 1'b0};
                s_inc_d = dx2 - dy2;
                s_sxd   = 2'sd1;
                s_sys   = 2'sd1;
                s_syd   = 2'sd1;
            end
            if (x_gt)
            begin
                s_sxs = -s_sxs;
                s_sxd = -s_sxd;
            end
            if (y_gt)
            begin
                s_sys = -s_sys;
                s_syd = -s_syd;
            end
        end
    end

    always_comb
    begin
        is_start = (op == OP_START);
        emit_ok  = is_start || active_reg;
        w_x      = is_start ? s_x : cur_x_reg;
        w_y      = is_start ? s_y : cur_y_reg;
        w_dec    = is_start ? s_dec : dec_reg;
        w_inc_s  = is_start ? s_inc_s : inc_s_reg;
        w_inc_d  = is_start ? s_inc_d : inc_d_reg;
        w_sxs    = is_start ? s_sxs : sxs_reg;
        w_sxd    = is_start ? s_sxd : sxd_reg;
        w_sys    = is_start ? s_sys : sys_reg;
        w_syd    = is_start ? s_syd : syd_reg;
        w_left   = is_start ? s_count : left_reg;
        w_color  = is_start ? color : color_reg;
        left_dec = w_left - NW'(1);
        last     = (left_dec == '0);

        straight = w_dec[DW-1];
        step_x   = straight ? w_sxs : w_sxd;
        step_y   = straight ? w_sys : w_syd;
        adv_x    = w_x + {{(CB-2){step_x[1]}}, step_x};
        adv_y    = w_y + {{(CB-2){step_y[1]}}, step_y};
        adv_dec  = straight ? (w_dec + {w_inc_s[SW-1], w_inc_s}) : (w_dec + w_inc_d);
    end

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        dec_next    = dec_reg;
        inc_s_next  = inc_s_reg;
        inc_d_next  = inc_d_reg;
        sxs_next    = sxs_reg;
        sxd_next    = sxd_reg;
        sys_next    = sys_reg;
        syd_next    = syd_reg;
        left_next   = left_reg;
        active_next = active_reg;
        color_next  = color_reg;
        if (fire && emit_ok)
        begin
            cur_x_next  = last ? w_x : adv_x;
            cur_y_next  = last ? w_y : adv_y;
            dec_next    = last ? w_dec : adv_dec;
            inc_s_next  = w_inc_s;
            inc_d_next  = w_inc_d;
            sxs_next    = w_sxs;
            sxd_next    = w_sxd;
            sys_next    = w_sys;
            syd_next    = w_syd;
            left_next   = left_dec;
            active_next = !last;
            color_next  = w_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dec_reg    <= '0;
            inc_s_reg  <= '0;
            inc_d_reg  <= '0;
            sxs_reg    <= '0;
            sxd_reg    <= '0;
            sys_reg    <= '0;
            syd_reg    <= '0;
            left_reg   <= '0;
            active_reg <= 1'b0;
            color_reg  <= '0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            dec_reg    <= dec_next;
            inc_s_reg  <= inc_s_next;
            inc_d_reg  <= inc_d_next;
            sxs_reg    <= sxs_next;
            sxd_reg    <= sxd_next;
            sys_reg    <= sys_next;
            syd_reg    <= syd_next;
            left_reg   <= left_next;
            active_reg <= active_next;
            color_reg  <= color_next;
        end
    end

    // An advance with no line gives an all-zero, invalid pixel.
    assign res_x     = emit_ok ? w_x : '0;
    assign res_y     = emit_ok ? w_y : '0;
    assign res_color = emit_ok ? w_color : '0;
    assign res_last  = emit_ok && last;
    assign res_valid = emit_ok;

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_last |=> !active_reg)
        else $error("line still active after its last pixel");

    a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> left_reg != '0)
        else $error("active line with no pixels left");

    a_invalid_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res_valid |-> op == OP_ADVANCE && !active_reg)
        else $error("invalid pixel produced while a line was available");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op == OP_START |=> $past(res_valid))
        else $error("start request produced no valid pixel");

endmodule

FILE: hw/rtl/bresenham_line_rasterizer.sv
// A request is held in the input register, its pixel in the result register.
// Throughput: one request per cycle while out_stall does not hold the
// result register, one pixel per request; the set-up of a new line and
// each Bresenham step are a single add, compare and select pass.
// Reset clears both register valids and leaves no line active.
module bresenham_line_rasterizer
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  op_t                          op,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_BITS-1:0] draw_color,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic        [COLOR_BITS-1:0] pixel_color,
    output logic                         last_pixel,
    output logic                         pixel_valid
);

    logic                         held_valid;
    op_t                          held_op;
    logic signed [COORD_BITS-1:0] held_x1;
    logic signed [COORD_BITS-1:0] held_y1;
    logic signed [COORD_BITS-1:0] held_x2;
    logic signed [COORD_BITS-1:0] held_y2;
    logic        [COLOR_BITS-1:0] held_color;
    logic                         out_load;
    logic                         fire;
    logic signed [COORD_BITS-1:0] res_x;
    logic signed [COORD_BITS-1:0] res_y;
    logic        [COLOR_BITS-1:0] res_color;
    logic                         res_last;
    logic                         res_valid;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic        [COLOR_BITS-1:0] pcolor_reg;
    logic                         plast_reg;
    logic                         pvalid_reg;

    // The result register may be refilled when empty or being taken.
    assign out_load = !out_valid_reg || !out_stall;
    assign fire     = held_valid && out_load;

    brl_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .draw_color (draw_color),
        .take       (out_load),
        .held_valid (held_valid),
        .held_op    (held_op),
        .held_x1    (held_x1),
        .held_y1    (held_y1),
        .held_x2    (held_x2),
        .held_y2    (held_y2),
        .held_color (held_color)
    );

    brl_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .op        (held_op),
        .x1        (held_x1),
        .y1        (held_y1),
        .x2        (held_x2),
        .y2        (held_y2),
        .color     (held_color),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_color (res_color),
        .res_last  (res_last),
        .res_valid (res_valid)
    );

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = held_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            px_reg     <= res_x;
            py_reg     <= res_y;
            pcolor_reg <= res_color;
            plast_reg  <= res_last;
            pvalid_reg <= res_valid;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcolor_reg;
    assign last_pixel  = plast_reg;
    assign pixel_valid = pvalid_reg;

endmodule

FILE: dv/line_pixel_checker.sv
module line_pixel_checker
    import brl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  op_t                          op,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic        [COLOR_BITS-1:0] draw_color,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    input  logic        [COLOR_BITS-1:0] pixel_color,
    input  logic                         last_pixel,
    input  logic                         pixel_valid,
    output int                           mismatches,
    output int                           pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS;

    typedef struct packed {
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   y;
        logic [COLOR_BITS-1:0]  color;
        logic                   last;
        logic                   valid;
    } pixel_t;

    pixel_t expected_pixels[$];

    // Rasteriser state, kept at the widths the hardware needs.
    logic signed [CB-1:0]   next_x;
    logic signed [CB-1:0]   next_y;
    logic signed [CB+2:0]   err_term;
    logic        [CB+1:0]   straight_inc;
    logic signed [CB+2:0]   diagonal_inc;
    logic signed [1:0]      sx_straight;
    logic signed [1:0]      sx_diag;
    logic signed [1:0]      sy_straight;
    logic signed [1:0]      sy_diag;
    logic        [CB:0]     remaining;
    logic                   drawing;
    logic [COLOR_BITS-1:0]  ink;

    task automatic rasterize(input op_t kind,
                             input logic signed [CB-1:0] x1,
                             input logic signed [CB-1:0] y1,
                             input logic signed [CB-1:0] x2,
                             input logic signed [CB-1:0] y2,
                             input logic [COLOR_BITS-1:0] color,
                             output pixel_t px);
        logic signed [CB:0] dx;
        logic signed [CB:0] dy;
        dx = (x1 > x2) ? (CB+1)'(x1) - (CB+1)'(x2) : (CB+1)'(x2) - (CB+1)'(x1);
        dy = (y1 > y2) ? (CB+1)'(y1) - (CB+1)'(y2) : (CB+1)'(y2) - (CB+1)'(y1);
        if (kind == OP_START)
        begin
            ink = color;
            sx_straight = 2'sd0;
            sx_diag = 2'sd0;
            sy_straight = 2'sd0;
            sy_diag = 2'sd0;
            if (x1 == x2 || y1 == y2)
            begin
                // Axis-aligned: a negative decision forces the straight step throughout.
                err_term = (CB+3)'(-1);
                straight_inc = '0;
                diagonal_inc = '0;
                if (x1 == x2)
                begin
                    next_x = x1;
                    next_y = (y1 < y2) ? y1 : y2;
                    sy_straight = 2'sd1;
                    remaining = dy + (CB+1)'(1);
                end
                else
                begin
                    next_y = y1;
                    next_x = (x1 < x2) ? x1 : x2;
                    sx_straight = 2'sd1;
                    remaining = dx + (CB+1)'(1);
                end
            end
            else
            begin
                if (dx >= dy)
                begin
                    remaining = dx + (CB+1)'(1);
                    err_term = (CB+3)'(2 * dy - dx);
                    straight_inc = (CB+2)'(2 * dy);
                    diagonal_inc = (CB+3)'(2 * (dy - dx));
                    sx_straight = 2'sd1;
                    sx_diag = 2'sd1;
                    sy_diag = 2'sd1;
                end
                else
                begin
                    remaining = dy + (CB+1)'(1);
                    err_term = (CB+3)'(2 * dx - dy);
                    straight_inc = (CB+2)'(2 * dx);
                    diagonal_inc = (CB+3)'(2 * (dx - dy));
                    sx_diag = 2'sd1;
                    sy_straight = 2'sd1;
                    sy_diag = 2'sd1;
                end
                if (x1 > x2)
                begin
                    sx_straight = -sx_straight;
                    sx_diag = -sx_diag;
                end
                if (y1 > y2)
                begin
                    sy_straight = -sy_straight;
                    sy_diag = -sy_diag;
                end
                next_x = x1;
                next_y = y1;
            end
        end
        else if (!drawing)
        begin
            px = '0;
            return;
        end
        remaining = remaining - (CB+1)'(1);
        px.x = next_x;
        px.y = next_y;
        px.color = ink;
        px.last = (remaining == '0);
        px.valid = 1'b1;
        drawing = !px.last;
        if (!px.last)
        begin
            if (err_term < 0)
            begin
                err_term = err_term + $signed({1'b0, straight_inc});
                next_x = next_x + CB'(sx_straight);
                next_y = next_y + CB'(sy_straight);
            end
            else
            begin
                err_term = err_term + diagonal_inc;
                next_x = next_x + CB'(sx_diag);
                next_y = next_y + CB'(sy_diag);
            end
        end
    endtask

    task automatic report_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        pixel_t fresh;
        if (!rst_n)
        begin
            next_x = '0;
            next_y = '0;
            err_term = '0;
            straight_inc = '0;
            diagonal_inc = '0;
            sx_straight = '0;
            sx_diag = '0;
            sy_straight = '0;
            sy_diag = '0;
            remaining = '0;
            drawing = 1'b0;
            ink = '0;
            expected_pixels.delete();
            mismatches = 0;
        end
        else
        begin
            // Results are retired before new requests are predicted, so a pixel can
            // never be matched against a request accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: pixel expected none actual x=%0d y=%0d valid=%0d",
                             $time, pixel_x, pixel_y, pixel_valid);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    report_field("pixel_x", want.x, pixel_x);
                    report_field("pixel_y", want.y, pixel_y);
                    report_field("pixel_color", want.color, pixel_color);
                    report_field("last_pixel", want.last, last_pixel);
                    report_field("pixel_valid", want.valid, pixel_valid);
                end
            end
            if (in_valid && !in_stall)
            begin
                rasterize(op, x_start, y_start, x_end, y_end, draw_color, fresh);
                expected_pixels.push_back(fresh);
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

FILE: dv/testbench.sv
module testbench
    import brl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 120;
    localparam int CYCLE_LIMIT  = 200000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    op_t                   op;
    coord_t                x_start;
    coord_t                y_start;
    coord_t                x_end;
    coord_t                y_end;
    logic [COLOR_BITS-1:0] draw_color;
    logic                  out_valid;
    logic                  out_stall;
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
    logic                  pixel_valid;

    int mismatches;
    int pending_pixels;
    int cycles;
    int stall_run;
    bit idling;
    int requests_sent;
    int lines_started;
    int advances_sent;
    int random_lines;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bresenham_line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .draw_color(draw_color),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
        .last_pixel(last_pixel), .pixel_valid(pixel_valid)
    );

    line_pixel_checker #(.COORD_BITS(COORD_BITS)) scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .draw_color(draw_color),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
        .last_pixel(last_pixel), .pixel_valid(pixel_valid),
        .mismatches(mismatches), .pending_pixels(pending_pixels)
    );

    // Pixel sink back-pressure in random bursts while idling is set.
    always @(negedge clk)
    begin
        if (!idling)
        begin
            stall_run = 0;
            out_stall = 1'b0;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall = 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_run = $urandom_range(1, 7) - 1;
            out_stall = 1'b1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    // Moves away from base by delta, reflecting back when the far end would leave range.
    function automatic coord_t offset_coord(coord_t base, int delta);
        int v;
        v = base + delta;
        if (v > COORD_MAX || v < COORD_MIN)
            v = base - delta;
        return coord_t'(v);
    endfunction

    task automatic send_request(input op_t kind, input coord_t xs, input coord_t ys,
                                input coord_t xe, input coord_t ye,
                                input logic [COLOR_BITS-1:0] color);
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid = 1'b1;
        op = kind;
        x_start = xs;
        y_start = ys;
        x_end = xe;
        y_end = ye;
        draw_color = color;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
        if (kind == OP_START)
            lines_started++;
        else
            advances_sent++;
    endtask

    // Advance requests carry random endpoint fields, which the block must ignore.
    task automatic advance_line(input int n);
        repeat (n) send_request(OP_ADVANCE, any_coord(), any_coord(), any_coord(),
                                any_coord(), $urandom);
    endtask

    task automatic drain_pixels();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pixels != 0) @(negedge clk);
    endtask

    initial
    begin
        int random_start;
        int span;
        int shape;
        int dxm;
        int dym;
        int pick;
        int count;
        int n_adv;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_START;
        x_start = '0;
        y_start = '0;
        x_end = '0;
        y_end = '0;
        draw_color = '0;
        out_stall = 1'b0;
        stall_run = 0;
        idling = 1'b1;
        requests_sent = 0;
        lines_started = 0;
        advances_sent = 0;
        random_lines = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines: idle advances, single points at the corners, reversed
        // axis-aligned lines, a full-span diagonal cut short by a new start, octants.
        advance_line(1);
        send_request(OP_START, 0, 0, 0, 0, 32'h0000_0000);
        advance_line(1);
        send_request(OP_START, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 32'hFFFF_FFFF);
        send_request(OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hA5A5_5A5A);
        send_request(OP_START, 3, 7, -1, 7, 32'h0000_00FF);
        advance_line(5);
        send_request(OP_START, -4, 2, -4, -1, 32'h1234_5678);
        advance_line(1);
        send_request(OP_START, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'h8000_0001);
        advance_line(2);
        send_request(OP_START, 0, 0, 5, 2, $urandom);
        advance_line(2);
        send_request(OP_START, 0, 0, -2, -5, $urandom);
        advance_line(1);
        send_request(OP_START, COORD_MIN, 0, COORD_MAX, 1, $urandom);
        advance_line(1);

        // Hold the next request back until every pixel so far has come out.
        drain_pixels();

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            idling = (requests_sent - random_start < RANDOM_ITEMS - QUIET_TAIL)
                     && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                advance_line(1);
            end
            else
            begin
                pick = $urandom_range(0, 19);
                span = (pick < 16) ? 15 : (pick < 19) ? 60 : COORD_MAX;
                shape = $urandom_range(0, 4);
                dxm = $urandom_range(1, span);
                dym = $urandom_range(1, span);
                case (shape)
                    0: begin dxm = 0; dym = 0; end
                    1: dym = 0;
                    2: dxm = 0;
                    3: dym = dxm;
                    default: ;
                endcase
                xs = any_coord();
                ys = any_coord();
                xe = offset_coord(xs, $urandom_range(0, 1) ? dxm : -dxm);
                ye = offset_coord(ys, $urandom_range(0, 1) ? dym : -dym);
                count = ((dxm > dym) ? dxm : dym) + 1;
                pick = $urandom_range(0, 9);
                if (count > 100)
                    n_adv = $urandom_range(0, 30);
                else if (pick < 6)
                    n_adv = count - 1;
                else if (pick < 8)
                    n_adv = count - 1 + $urandom_range(1, 3);
                else
                    n_adv = $urandom_range(0, count - 1);
                send_request(OP_START, xs, ys, xe, ye, $urandom);
                advance_line(n_adv);
                random_lines++;
            end
        end

        idling = 1'b0;
        drain_pixels();
        repeat (8) @(negedge clk);

        $display("Covered %0d requests: %0d line starts (%0d random lines), %0d advances.",
                 requests_sent, lines_started, random_lines, advances_sent);
        $display("Lines ran complete, overran into idle advances or were cut short by a start.");
        if (mismatches == 0 && pending_pixels == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
